// File: hw/rtl/als_pkg.sv
package als_pkg;

   localparam int LED_COUNT = 256;
   localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int LED_CNT_W = $clog2(LED_COUNT + 1);

   localparam int PIXEL_W      = 32;
   localparam int LOCATION_W   = 8;
   localparam int TICK_W       = 16;
   localparam int BIT_IDX_W    = 5;
   localparam int PIX_COUNT_W  = 9;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   localparam logic [BIT_IDX_W-1:0] GRB_LAST_BIT  = 5'd23;
   localparam logic [BIT_IDX_W-1:0] GRBW_LAST_BIT = 5'd31;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2,
      PH_GAP  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      REG_PIXEL_COUNT = 3'd0,
      REG_CHANNEL_MODE = 3'd1,
      REG_SHORT_HIGH = 3'd2,
      REG_LONG_HIGH = 3'd3,
      REG_LOW_TICKS = 3'd4,
      REG_GAP_TICKS = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [PIX_COUNT_W-1:0] pixel_count;
      logic                   channel_mode;
      logic [TICK_W-1:0]      short_high_ticks;
      logic [TICK_W-1:0]      long_high_ticks;
      logic [TICK_W-1:0]      low_ticks;
      logic [TICK_W-1:0]      gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic                 wr_en;
      logic [LED_IDX_W-1:0] wr_addr;
      logic [PIXEL_W-1:0]   wr_data;
      logic [LED_IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic frame_done;
      logic accepted;
      logic busy_res;
      logic line_level;
   } result_type;

   function automatic logic [7:0] sq_byte(input logic [7:0] b);
      logic [15:0] p;
      p = 16'(b) * 16'(b);
      return p[15:8];
   endfunction

   function automatic logic [PIXEL_W-1:0] gamma_word(input logic [PIXEL_W-1:0] w);
      return {sq_byte(w[31:24]), sq_byte(w[23:16]), sq_byte(w[15:8]), sq_byte(w[7:0])};
   endfunction

endpackage

// File: hw/rtl/als_ram.sv
module als_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/als_pixel_store.sv
module als_pixel_store (
   input  logic                         clock,
   input  logic                         reset,
   input  als_pkg::mem_req_type         mem_req,
   output logic [als_pkg::PIXEL_W-1:0]  pixel_gamma
);
   import als_pkg::*;

   logic [PIXEL_W-1:0] rd_data;
   logic [LED_COUNT-1:0] valid_ff, valid_in;
   logic rvalid_ff, rvalid_in;
   logic fwd_ff, fwd_in;
   logic [PIXEL_W-1:0] fwd_data_ff;
   logic [PIXEL_W-1:0] raw_word;

   als_ram #(
      .WIDTH(PIXEL_W),
      .DEPTH(LED_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_req.wr_en),
      .wr_addr(mem_req.wr_addr),
      .wr_data(mem_req.wr_data),
      .rd_addr(mem_req.rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.wr_en) begin
         valid_in[mem_req.wr_addr] = 1'b1;
      end
      rvalid_in = valid_ff[mem_req.rd_addr];
      fwd_in = mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rvalid_ff <= rvalid_in;
         fwd_ff    <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= mem_req.wr_data;
   end

   // write bypass, then unwritten entries read as zero
   always_comb begin
      if (fwd_ff) begin
         raw_word = fwd_data_ff;
      end else if (rvalid_ff) begin
         raw_word = rd_data;
      end else begin
         raw_word = '0;
      end
      pixel_gamma = gamma_word(raw_word);
   end

endmodule

// File: hw/rtl/als_engine.sv
module als_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  als_pkg::op_type                 op,
   input  logic [als_pkg::LOCATION_W-1:0]  location,
   input  logic [als_pkg::PIXEL_W-1:0]     pixel_word,
   input  als_pkg::cfg_type                cfg,
   input  logic [als_pkg::PIXEL_W-1:0]     pixel_gamma,
   output als_pkg::mem_req_type            mem_req,
   output als_pkg::result_type             result
);
   import als_pkg::*;

   phase_type phase_ff, phase_in;
   logic [LED_IDX_W-1:0] pixel_index_ff, pixel_index_in;
   logic [BIT_IDX_W-1:0] bit_index_ff, bit_index_in;
   logic [TICK_W-1:0] tick_count_ff, tick_count_in;
   logic [PIXEL_W-1:0] shift_word_ff, shift_word_in;

   logic [LED_CNT_W-1:0] eff_count;
   logic idle, loc_ok, more_pixels;
   logic [PIXEL_W-1:0] load_shift;
   logic [BIT_IDX_W-1:0] load_bits;
   logic [TICK_W-1:0] load_ticks, next_bit_ticks;

   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

   always_comb begin
      if (cfg.pixel_count == '0) begin
         eff_count = LED_CNT_W'(1);
      end else if (32'(cfg.pixel_count) > LED_COUNT) begin
         eff_count = LED_CNT_W'(LED_COUNT);
      end else begin
         eff_count = LED_CNT_W'(cfg.pixel_count);
      end
      idle = (phase_ff == PH_IDLE);
      loc_ok = (32'(location) < 32'(eff_count)) && (32'(location) < LED_COUNT);
      more_pixels = (32'(pixel_index_ff) + 32'd1) < 32'(eff_count);

      if (cfg.channel_mode) begin
         load_shift = {pixel_gamma[23:16], pixel_gamma[31:24], pixel_gamma[15:8],
                       pixel_gamma[7:0]};
         load_bits = GRBW_LAST_BIT;
      end else begin
         load_shift = {pixel_gamma[15:8], pixel_gamma[23:16], pixel_gamma[7:0], 8'h00};
         load_bits = GRB_LAST_BIT;
      end
      load_ticks = load_shift[PIXEL_W-1] ? at_least_one(cfg.long_high_ticks)
                                         : at_least_one(cfg.short_high_ticks);
      next_bit_ticks = shift_word_ff[PIXEL_W-2] ? at_least_one(cfg.long_high_ticks)
                                                : at_least_one(cfg.short_high_ticks);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pixel_index_ff <= '0;
         bit_index_ff   <= '0;
         tick_count_ff  <= '0;
         shift_word_ff  <= '0;
      end else begin
         phase_ff       <= phase_in;
         pixel_index_ff <= pixel_index_in;
         bit_index_ff   <= bit_index_in;
         tick_count_ff  <= tick_count_in;
         shift_word_ff  <= shift_word_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      pixel_index_in = pixel_index_ff;
      bit_index_in   = bit_index_ff;
      tick_count_in  = tick_count_ff;
      shift_word_in  = shift_word_ff;
      result         = '0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = LED_IDX_W'(location);
      mem_req.wr_data = pixel_word;

      if (fire) begin
         unique case (op)
            OP_WRITE: begin
               result.busy_res = !idle;
               if (idle && loc_ok) begin
                  mem_req.wr_en   = 1'b1;
                  result.accepted = 1'b1;
               end
            end
            OP_START: begin
               result.busy_res = 1'b1;
               if (idle) begin
                  pixel_index_in  = '0;
                  shift_word_in   = load_shift;
                  bit_index_in    = load_bits;
                  phase_in        = PH_HIGH;
                  tick_count_in   = load_ticks;
                  result.accepted = 1'b1;
               end
            end
            OP_TICK: begin
               if (!idle) begin
                  result.busy_res   = 1'b1;
                  result.line_level = (phase_ff == PH_HIGH);
                  tick_count_in     = tick_count_ff - TICK_W'(1);
                  if (tick_count_ff == TICK_W'(1)) begin
                     unique case (phase_ff)
                        PH_HIGH: begin
                           phase_in      = PH_LOW;
                           tick_count_in = at_least_one(cfg.low_ticks);
                        end
                        PH_LOW: begin
                           if (bit_index_ff != '0) begin
                              bit_index_in  = bit_index_ff - BIT_IDX_W'(1);
                              shift_word_in = {shift_word_ff[PIXEL_W-2:0], 1'b0};
                              phase_in      = PH_HIGH;
                              tick_count_in = next_bit_ticks;
                           end else if (more_pixels) begin
                              pixel_index_in = pixel_index_ff + LED_IDX_W'(1);
                              shift_word_in  = load_shift;
                              bit_index_in   = load_bits;
                              phase_in       = PH_HIGH;
                              tick_count_in  = load_ticks;
                           end else begin
                              phase_in      = PH_GAP;
                              tick_count_in = at_least_one(cfg.gap_ticks);
                           end
                        end
                        PH_GAP: begin
                           phase_in          = PH_IDLE;
                           pixel_index_in    = '0;
                           bit_index_in      = '0;
                           shift_word_in     = '0;
                           result.frame_done = 1'b1;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
            default: begin
               result.busy_res = !idle;
            end
         endcase
      end

      // prefetch the pixel that the next load will need
      if (phase_in == PH_IDLE) begin
         mem_req.rd_addr = '0;
      end else begin
         mem_req.rd_addr = pixel_index_in + LED_IDX_W'(1);
      end
   end

endmodule

// File: hw/rtl/addressable_led_serializer_unit.sv
// channel   direction  handshake                 payload
// req       in         req_tvalid / req_tready   tuser: operation; tdata: location, pixel_word
// rsp       out        rsp_tvalid / rsp_tready   tdata: line_level, busy_res, accepted, frame_done
// csr       in         psel / penable / pready   apb registers at 4*index, pready always high
//
// one request per clock if not full; each gives one response, in the next cycle at the earliest
// the frame store is a single-port-write, registered-read ram; the pixel for the next load
// is read ahead, so a load never waits on the ram
// reset clears the store at once through per-entry valid bits; no clearing pass
// a two-entry response buffer lets requests flow while one response waits
module addressable_led_serializer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [1:0]                        req_tuser,   // operation
   input  logic [39:0]                       req_tdata,   // location, pixel_word
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // line_level, busy_res, accepted,
                                                          // frame_done, zero fill
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [als_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [als_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [als_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import als_pkg::*;

   cfg_type cfg_ff, cfg_in;
   reg_index_type csr_index;
   logic csr_write;

   logic fire, pop;
   mem_req_type mem_req;
   result_type result;
   logic [PIXEL_W-1:0] pixel_gamma;

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in, slot1_ff, slot1_in;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_PIXEL_COUNT:  cfg_in.pixel_count      = csr_pwdata[PIX_COUNT_W-1:0];
            REG_CHANNEL_MODE: cfg_in.channel_mode     = csr_pwdata[0];
            REG_SHORT_HIGH:   cfg_in.short_high_ticks = csr_pwdata[TICK_W-1:0];
            REG_LONG_HIGH:    cfg_in.long_high_ticks  = csr_pwdata[TICK_W-1:0];
            REG_LOW_TICKS:    cfg_in.low_ticks        = csr_pwdata[TICK_W-1:0];
            REG_GAP_TICKS:    cfg_in.gap_ticks        = csr_pwdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PIXEL_COUNT:  csr_prdata = CSR_DATA_W'(cfg_ff.pixel_count);
         REG_CHANNEL_MODE: csr_prdata = CSR_DATA_W'(cfg_ff.channel_mode);
         REG_SHORT_HIGH:   csr_prdata = CSR_DATA_W'(cfg_ff.short_high_ticks);
         REG_LONG_HIGH:    csr_prdata = CSR_DATA_W'(cfg_ff.long_high_ticks);
         REG_LOW_TICKS:    csr_prdata = CSR_DATA_W'(cfg_ff.low_ticks);
         REG_GAP_TICKS:    csr_prdata = CSR_DATA_W'(cfg_ff.gap_ticks);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_count      <= PIX_COUNT_W'(256);
         cfg_ff.channel_mode     <= 1'b0;
         cfg_ff.short_high_ticks <= TICK_W'(24);
         cfg_ff.long_high_ticks  <= TICK_W'(64);
         cfg_ff.low_ticks        <= TICK_W'(64);
         cfg_ff.gap_ticks        <= TICK_W'(800);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign fire       = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {4'b0000, slot0_ff};

   als_pixel_store u_store (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .pixel_gamma(pixel_gamma)
   );

   als_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .op         (op_type'(req_tuser)),
      .location   (req_tdata[7:0]),
      .pixel_word (req_tdata[39:8]),
      .cfg        (cfg_ff),
      .pixel_gamma(pixel_gamma),
      .mem_req    (mem_req),
      .result     (result)
   );

   // two-entry response buffer, slot0 is the head
   always_comb begin
      count_in = count_ff + {1'b0, fire} - {1'b0, pop};
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = (count_ff == 2'd2) ? slot1_ff : result;
      end else if (count_ff == 2'd0) begin
         slot0_in = result;
      end
      if (fire && !pop && (count_ff == 2'd1)) begin
         slot1_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// File: tb/testbench.sv
module testbench;
   import als_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_ITEMS = 200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser = '0;   // operation
   logic [39:0]           req_tdata = '0;   // location, pixel_word
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // line_level, busy_res, accepted, frame_done, zero fill
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // serializer state as the testbench sees it
   logic [PIXEL_W-1:0] pixel_mem [LED_COUNT];
   logic [7:0]         walk_pixel;
   logic [4:0]         walk_bit;
   phase_type          walk_phase;
   logic [TICK_W-1:0]  walk_ticks;
   logic [31:0]        walk_bits;
   cfg_type            led_cfg;

   result_type pending_results [$];
   int failures = 0;
   int items_sent = 0;
   bit idle_on = 1'b1;
   int hold_req = 0;
   int hold_ack = 0;
   int quiet_cycles = 0;

   addressable_led_serializer_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   function automatic void reset_model();
      foreach (pixel_mem[i]) pixel_mem[i] = '0;
      walk_pixel = '0;
      walk_bit = '0;
      walk_phase = PH_IDLE;
      walk_ticks = '0;
      walk_bits = '0;
      led_cfg.pixel_count = 9'd256;
      led_cfg.channel_mode = 1'b0;
      led_cfg.short_high_ticks = 16'd24;
      led_cfg.long_high_ticks = 16'd64;
      led_cfg.low_ticks = 16'd64;
      led_cfg.gap_ticks = 16'd800;
   endfunction

   function automatic logic [7:0] dim_byte(input logic [7:0] b);
      logic [15:0] sq;
      sq = b * b;
      return sq[15:8];
   endfunction

   function automatic int led_count();
      int n;
      n = led_cfg.pixel_count;
      if (n < 1) n = 1;
      if (n > LED_COUNT) n = LED_COUNT;
      return n;
   endfunction

   function automatic logic [15:0] ticks_or_one(input logic [15:0] t);
      return (t == 16'd0) ? 16'd1 : t;
   endfunction

   function automatic void open_high_phase();
      walk_phase = PH_HIGH;
      walk_ticks = walk_bits[31] ? ticks_or_one(led_cfg.long_high_ticks)
                                 : ticks_or_one(led_cfg.short_high_ticks);
   endfunction

   function automatic void load_led();
      logic [31:0] g;
      g = {dim_byte(pixel_mem[walk_pixel][31:24]), dim_byte(pixel_mem[walk_pixel][23:16]),
           dim_byte(pixel_mem[walk_pixel][15:8]), dim_byte(pixel_mem[walk_pixel][7:0])};
      if (led_cfg.channel_mode) begin
         walk_bits = {g[23:16], g[31:24], g[15:8], g[7:0]};
         walk_bit = GRBW_LAST_BIT;
      end else begin
         walk_bits = {g[15:8], g[23:16], g[7:0], 8'h00};
         walk_bit = GRB_LAST_BIT;
      end
      open_high_phase();
   endfunction

   function automatic void next_bit_or_pixel();
      if (walk_bit != 5'd0) begin
         walk_bit = walk_bit - 5'd1;
         walk_bits = walk_bits << 1;
         open_high_phase();
      end else if (int'(walk_pixel) + 1 < led_count()) begin
         walk_pixel = walk_pixel + 8'd1;
         load_led();
      end else begin
         walk_phase = PH_GAP;
         walk_ticks = ticks_or_one(led_cfg.gap_ticks);
      end
   endfunction

   function automatic result_type predict_led_item(input logic [1:0] op, input logic [7:0] loc,
                                                   input logic [31:0] word);
      result_type r;
      r = '0;
      case (op)
         OP_WRITE: begin
            if (walk_phase == PH_IDLE && int'(loc) < led_count()) begin
               pixel_mem[loc] = word;
               r.accepted = 1'b1;
            end
            r.busy_res = (walk_phase != PH_IDLE);
         end
         OP_START: begin
            if (walk_phase == PH_IDLE) begin
               walk_pixel = '0;
               load_led();
               r.accepted = 1'b1;
            end
            r.busy_res = 1'b1;
         end
         OP_TICK: begin
            if (walk_phase != PH_IDLE) begin
               r.busy_res = 1'b1;
               r.line_level = (walk_phase == PH_HIGH);
               walk_ticks = walk_ticks - 16'd1;
               if (walk_ticks == 16'd0) begin
                  case (walk_phase)
                     PH_HIGH: begin
                        walk_phase = PH_LOW;
                        walk_ticks = ticks_or_one(led_cfg.low_ticks);
                     end
                     PH_LOW: next_bit_or_pixel();
                     default: begin
                        walk_phase = PH_IDLE;
                        walk_pixel = '0;
                        walk_bit = '0;
                        walk_bits = '0;
                        r.frame_done = 1'b1;
                     end
                  endcase
               end
            end
         end
         default: r.busy_res = (walk_phase != PH_IDLE);
      endcase
      return r;
   endfunction

   function automatic logic [31:0] reg_value(input reg_index_type idx);
      case (idx)
         REG_PIXEL_COUNT:  return 32'(led_cfg.pixel_count);
         REG_CHANNEL_MODE: return 32'(led_cfg.channel_mode);
         REG_SHORT_HIGH:   return 32'(led_cfg.short_high_ticks);
         REG_LONG_HIGH:    return 32'(led_cfg.long_high_ticks);
         REG_LOW_TICKS:    return 32'(led_cfg.low_ticks);
         default:          return 32'(led_cfg.gap_ticks);
      endcase
   endfunction

   function automatic void check_field(input string field, input logic want, input logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d actual %0d", field, want, got);
         failures++;
      end
   endfunction

   task automatic csr_transfer(input bit is_write, input reg_index_type idx,
                               input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (is_write) begin
         case (idx)
            REG_PIXEL_COUNT:  led_cfg.pixel_count = value[8:0];
            REG_CHANNEL_MODE: led_cfg.channel_mode = value[0];
            REG_SHORT_HIGH:   led_cfg.short_high_ticks = value[15:0];
            REG_LONG_HIGH:    led_cfg.long_high_ticks = value[15:0];
            REG_LOW_TICKS:    led_cfg.low_ticks = value[15:0];
            default:          led_cfg.gap_ticks = value[15:0];
         endcase
      end else if (csr_prdata !== reg_value(idx)) begin
         $error("%s read mismatch: expected %0d actual %0d", idx.name(), reg_value(idx),
                csr_prdata);
         failures++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      csr_transfer(1'b1, idx, value);
   endtask

   task automatic check_registers();
      reg_index_type idx;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_transfer(1'b0, idx, '0);
         idx = idx.next();
      end
   endtask

   task automatic send_item(input logic [1:0] op, input logic [7:0] loc, input logic [31:0] word);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {word, loc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_led_item(op, loc, word));
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 8'($urandom), $urandom);
   endtask

   task automatic run_to_idle();
      while (walk_phase != PH_IDLE) send_tick();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_location();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, led_count() - 1));
   endfunction

   task automatic set_timing(input int count, input bit mode, input int short_t, input int long_t,
                             input int low_t, input int gap_t);
      write_reg(REG_PIXEL_COUNT, count);
      write_reg(REG_CHANNEL_MODE, mode);
      write_reg(REG_SHORT_HIGH, short_t);
      write_reg(REG_LONG_HIGH, long_t);
      write_reg(REG_LOW_TICKS, low_t);
      write_reg(REG_GAP_TICKS, gap_t);
   endtask

   // reset values, cleared store and a default-timed frame cut down to one short pixel
   task automatic test_default_frame();
      check_registers();
      send_item(OP_WRITE, 8'd0, 32'hffff_ffff);
      send_item(OP_WRITE, 8'd255, 32'h1234_5678);
      send_item(OP_START, 8'd0, 32'h0);
      send_item(OP_WRITE, 8'd1, 32'hdead_beef);
      send_item(OP_START, 8'd0, 32'h0);
      send_item(OP_UNUSED, 8'hff, 32'hffff_ffff);
      repeat (20) send_tick();
      wait_drained();
      write_reg(REG_PIXEL_COUNT, 1);
      write_reg(REG_SHORT_HIGH, 1);
      write_reg(REG_LONG_HIGH, 1);
      write_reg(REG_LOW_TICKS, 1);
      write_reg(REG_GAP_TICKS, 1);
      run_to_idle();
      wait_drained();
   endtask

   // count clamping, range rejection and the unused operation while idle and mid-frame
   task automatic test_write_limits();
      set_timing(0, 1'b0, 1, 2, 1, 1);
      send_item(OP_WRITE, 8'd0, 32'h00ff_00ff);
      send_item(OP_WRITE, 8'd1, 32'hff00_ff00);
      send_item(OP_WRITE, 8'd255, 32'h0);
      send_item(OP_UNUSED, 8'd0, 32'h0);
      send_tick();
      send_item(OP_START, 8'd0, 32'h0);
      run_to_idle();
      wait_drained();
      write_reg(REG_PIXEL_COUNT, 3);
      send_item(OP_WRITE, 8'd2, 32'h8080_8080);
      send_item(OP_WRITE, 8'd3, 32'h1111_1111);
      send_item(OP_START, 8'd0, 32'h0);
      send_item(OP_UNUSED, 8'd2, 32'h0);
      run_to_idle();
      wait_drained();
   endtask

   task automatic test_grbw_frame();
      set_timing(2, 1'b1, 2, 3, 1, 4);
      send_item(OP_WRITE, 8'd0, 32'h80ff_1000);
      send_item(OP_WRITE, 8'd1, 32'h0180_ffff);
      send_item(OP_START, 8'd0, 32'h0);
      run_to_idle();
      wait_drained();
   endtask

   // zero in any duration register counts as one tick
   task automatic test_zero_durations();
      set_timing(1, 1'b0, 0, 0, 0, 0);
      send_item(OP_WRITE, 8'd0, $urandom);
      send_item(OP_START, 8'd0, 32'h0);
      run_to_idle();
      wait_drained();
   endtask

   task automatic test_midframe_change();
      set_timing(3, 1'b0, 1, 2, 1, 2);
      send_item(OP_WRITE, 8'd0, $urandom);
      send_item(OP_WRITE, 8'd1, $urandom);
      send_item(OP_WRITE, 8'd2, $urandom);
      send_item(OP_START, 8'd0, 32'h0);
      repeat (10) send_tick();
      wait_drained();
      write_reg(REG_CHANNEL_MODE, 1);
      write_reg(REG_PIXEL_COUNT, 2);
      write_reg(REG_SHORT_HIGH, 3);
      write_reg(REG_LOW_TICKS, 2);
      repeat (30) send_tick();
      wait_drained();
      write_reg(REG_PIXEL_COUNT, 0);
      run_to_idle();
      wait_drained();
      check_registers();
   endtask

   // response side held off long enough for the request side to back up
   task automatic test_backpressure();
      int k;
      set_timing(1, 1'b0, 1, 2, 1, 3);
      hold_req++;
      for (k = 0; k < 60; k++) begin
         if (k % 7 == 0) send_item(2'($urandom_range(0, 3)), pick_location(), $urandom);
         else send_tick();
      end
      wait_drained();
      send_item(OP_START, 8'd0, 32'h0);
      run_to_idle();
      wait_drained();
   endtask

   task automatic randomise_config();
      if ($urandom_range(0, 1))
         write_reg(REG_PIXEL_COUNT, ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3));
      if ($urandom_range(0, 1)) write_reg(REG_CHANNEL_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) write_reg(REG_SHORT_HIGH, $urandom_range(0, 3));
      if ($urandom_range(0, 1)) write_reg(REG_LONG_HIGH, $urandom_range(0, 3));
      if ($urandom_range(0, 1)) write_reg(REG_LOW_TICKS, $urandom_range(0, 3));
      if ($urandom_range(0, 1)) write_reg(REG_GAP_TICKS, $urandom_range(0, 6));
   endtask

   task automatic test_random_traffic();
      int first_item, writes, k, budget;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         wait_drained();
         randomise_config();
         writes = $urandom_range(0, 4);
         for (k = 0; k < writes; k++) send_item(OP_WRITE, pick_location(), $urandom);
         if ($urandom_range(0, 9) == 0) send_item(OP_UNUSED, pick_location(), $urandom);
         if ($urandom_range(0, 9) != 0) send_item(OP_START, 8'($urandom), $urandom);
         // some frames are cut short and finished under the next settings
         budget = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : 100000;
         while (walk_phase != PH_IDLE && budget > 0) begin
            if ($urandom_range(0, 9) == 0)
               send_item(2'($urandom_range(0, 3)), pick_location(), $urandom);
            else
               send_tick();
            budget--;
         end
         repeat ($urandom_range(0, 3)) send_tick();
      end
      wait_drained();
   endtask

   // widest frame cut short, widest durations read back, longer phases, with no idling
   task automatic test_extremes();
      idle_on = 1'b0;
      wait_drained();
      set_timing(511, 1'b1, 1, 1, 1, 1);
      send_item(OP_WRITE, 8'd255, $urandom);
      send_item(OP_WRITE, 8'd0, 32'hffff_ffff);
      send_item(OP_START, 8'd0, 32'h0);
      repeat (70) send_tick();
      wait_drained();
      write_reg(REG_PIXEL_COUNT, 1);
      run_to_idle();
      wait_drained();
      set_timing(1, 1'b0, 65535, 65535, 65535, 65535);
      check_registers();
      set_timing(1, 1'b0, 20, 25, 15, 30);
      // only the last bit of the pixel is a one after squaring
      send_item(OP_WRITE, 8'd0, 32'h0000_0010);
      send_item(OP_START, 8'd0, 32'h0);
      repeat (20 + 14) send_tick();
      wait_drained();
      write_reg(REG_SHORT_HIGH, 1);
      write_reg(REG_LOW_TICKS, 1);
      run_to_idle();
      wait_drained();
      check_registers();
   endtask

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_frame();
      test_write_limits();
      test_grbw_frame();
      test_zero_durations();
      test_midframe_change();
      test_backpressure();
      test_random_traffic();
      test_extremes();
      wait_drained();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : rsp_side
      int burst;
      forever begin
         @(posedge clock);
         if (hold_req != hold_ack) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_ack = hold_req;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 13);
            rsp_tready <= 1'b0;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[3:0]);
         if (pending_results.size() == 0) begin
            $error("response transaction with nothing pending: %b", rsp_tdata);
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("line_level", want.line_level, got.line_level);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("accepted", want.accepted, got.accepted);
            check_field("frame_done", want.frame_done, got.frame_done);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: addressable_led_serializer_unit.f
hw/rtl/als_pkg.sv
hw/rtl/als_ram.sv
hw/rtl/als_pixel_store.sv
hw/rtl/als_engine.sv
hw/rtl/addressable_led_serializer_unit.sv
tb/testbench.sv
